FILE: src/ims_pkg.sv
// shared types, constants and the state table of the ice maker sequencer
`default_nettype none
package ims_pkg;

  localparam int TIMER_BITS_DEF = 20;
  localparam int COUNT_BITS_DEF = 16;
  localparam int MAX_CHAIN_DEF  = 9;

  localparam int LIMIT_W    = 20;
  localparam int STATE_W    = 4;
  localparam int RELAY_W    = 4;
  localparam int BATCH_W    = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;

  localparam logic [STATE_W-1:0] NUM_STATES = 4'd9;
  localparam logic [STATE_W-1:0] COOL_STATE = 4'd0;
  localparam logic [STATE_W-1:0] DROP_STATE = 4'd5;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_START_STATE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAKE_ICE    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DROP_REFILL = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DROP        = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CLEANUP     = 3'd4;

  localparam logic [LIMIT_W-1:0] MAKE_ICE_RST    = 20'd600000;
  localparam logic [LIMIT_W-1:0] DROP_REFILL_RST = 20'd60000;
  localparam logic [LIMIT_W-1:0] DROP_RST        = 20'd40000;
  localparam logic [LIMIT_W-1:0] CLEANUP_RST     = 20'd120000;
  localparam logic [LIMIT_W-1:0] NO_LIMIT_LEFT   = '1;

  // relay patterns: bit0 hot gas, bit1 pump, bit2 water, bit3 compressor
  localparam logic [RELAY_W-1:0] RLY_COMP_PUMP     = 4'd10;
  localparam logic [RELAY_W-1:0] RLY_COMP_GAS      = 4'd9;
  localparam logic [RELAY_W-1:0] RLY_COMP_WTR_GAS  = 4'd13;
  localparam logic [RELAY_W-1:0] RLY_COMP_PUMP_GAS = 4'd11;
  localparam logic [RELAY_W-1:0] RLY_PUMP          = 4'd2;
  localparam logic [RELAY_W-1:0] RLY_PUMP_WTR      = 4'd6;
  localparam logic [RELAY_W-1:0] RLY_OFF           = 4'd0;

  typedef enum logic [1:0] {
    W_NONE = 2'd0,
    W_LOW  = 2'd1,
    W_HIGH = 2'd2
  } watch_e;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] limit_reg;  // REG_START_STATE means no limit
    watch_e                bin_watch;
    watch_e                evap_watch;
    logic [RELAY_W-1:0]    relays;
    logic [STATE_W-1:0]    next;
  } seq_entry_t;

  // controller to datapath
  typedef struct packed {
    logic cfg_we;
    logic tick;
    logic restart;
    logic enter_next;
    logic load_out;
  } ims_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ends;
  } ims_sts_t;

  function automatic seq_entry_t seq_lookup(input logic [STATE_W-1:0] s);
    seq_entry_t e;
    unique case (s)
      4'd0:    e = '{REG_START_STATE, W_NONE, W_HIGH, RLY_COMP_PUMP,     4'd1};
      4'd1:    e = '{REG_MAKE_ICE,    W_NONE, W_NONE, RLY_COMP_PUMP,     4'd2};
      4'd2:    e = '{REG_START_STATE, W_NONE, W_LOW,  RLY_COMP_GAS,      4'd3};
      4'd3:    e = '{REG_START_STATE, W_LOW,  W_NONE, RLY_OFF,           4'd4};
      4'd4:    e = '{REG_DROP_REFILL, W_NONE, W_NONE, RLY_COMP_WTR_GAS,  4'd5};
      4'd5:    e = '{REG_DROP,        W_NONE, W_NONE, RLY_COMP_PUMP_GAS, 4'd0};
      4'd6:    e = '{REG_START_STATE, W_NONE, W_LOW,  RLY_COMP_GAS,      4'd7};
      4'd7:    e = '{REG_CLEANUP,     W_NONE, W_NONE, RLY_PUMP,          4'd8};
      4'd8:    e = '{REG_START_STATE, W_NONE, W_NONE, RLY_PUMP_WTR,      4'd7};
      default: e = '{REG_START_STATE, W_NONE, W_HIGH, RLY_COMP_PUMP,     4'd1};
    endcase
    return e;
  endfunction

  function automatic logic watch_hit(input watch_e w, input logic level);
    return ((w == W_LOW) && !level) || ((w == W_HIGH) && level);
  endfunction

endpackage
`default_nettype wire

FILE: src/ims_ctrl.sv
// controller state machine: accepts beats, steps the transition chain, loads results
`default_nettype none
module ims_ctrl
  import ims_pkg::*;
#(
  parameter int MAX_CHAIN = MAX_CHAIN_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_axis_tvalid,
  output logic          s_axis_tready,
  input  wire logic     s_axis_tuser,
  output logic          m_axis_tvalid,
  input  wire logic     m_axis_tready,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire ims_sts_t sts_i,
  output ims_cmd_t      cmd_o
);

  localparam int CHAIN_W = $clog2(MAX_CHAIN + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_FIN
  } ctrl_state_e;

  ctrl_state_e        state_q, state_d;
  logic [CHAIN_W-1:0] chain_q, chain_d;
  logic               out_valid_q, out_valid_d;
  logic               accept, out_free;

  assign accept   = (state_q == ST_IDLE) && s_axis_tvalid;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    state_d          = state_q;
    chain_d          = chain_q;
    out_valid_d      = out_valid_q && !m_axis_tready;
    cmd_o            = '0;
    cmd_o.cfg_we     = cfg_valid_i && (state_q == ST_IDLE);
    cmd_o.tick       = accept && !s_axis_tuser;
    cmd_o.restart    = accept && s_axis_tuser;
    unique case (state_q)
      ST_IDLE: begin
        chain_d = '0;
        if (accept) begin
          state_d = s_axis_tuser ? ST_FIN : ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts_i.ends && (chain_q < CHAIN_W'(MAX_CHAIN))) begin
          cmd_o.enter_next = 1'b1;
          chain_d          = chain_q + 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/ims_dp.sv
// datapath: dwell limits, state, timer, batch counter and result register
`default_nettype none
module ims_dp
  import ims_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [LIMIT_W-1:0]      cfg_data_i,
  input  wire logic [IN_DATA_W-1:0]    in_data_i,
  input  wire ims_cmd_t                cmd_i,
  output ims_sts_t                     sts_o,
  output logic [OUT_DATA_W-1:0]        out_data_o
);

  localparam int CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

  logic [STATE_W-1:0]    cur_state_q, cur_state_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic [RELAY_W-1:0]    relay_q, relay_d;
  logic [COUNT_BITS-1:0] batch_q, batch_d;
  logic [LIMIT_W-1:0]    lim_q [1:4];
  logic                  bin_q, evap_q;
  logic [OUT_DATA_W-1:0] out_q;

  seq_entry_t                    cur_e, tgt_e;
  logic                          enter, has_limit, past_limit, start_ok;
  logic [STATE_W-1:0]            target;
  logic [LIMIT_W-1:0]            limit, time_left;
  logic [CMP_W-1:0]              lim_ext, el_ext;
  logic [COUNT_BITS+BATCH_W-1:0] batch_ext;

  assign cur_e     = seq_lookup(cur_state_q);
  assign has_limit = (cur_e.limit_reg != REG_START_STATE);
  always_comb begin
    case (cur_e.limit_reg)
      REG_MAKE_ICE:    limit = lim_q[1];
      REG_DROP_REFILL: limit = lim_q[2];
      REG_DROP:        limit = lim_q[3];
      REG_CLEANUP:     limit = lim_q[4];
      default:         limit = '0;
    endcase
  end
  assign lim_ext    = CMP_W'(limit);
  assign el_ext     = CMP_W'(elapsed_q);
  assign past_limit = (el_ext >= lim_ext);
  assign time_left  = !has_limit ? NO_LIMIT_LEFT :
                      past_limit ? '0 : LIMIT_W'(lim_ext - el_ext);

  assign sts_o.ends = (has_limit && past_limit) ||
                      watch_hit(cur_e.evap_watch, evap_q) ||
                      watch_hit(cur_e.bin_watch, bin_q);

  // start state write takes effect only when its low state bits give a valid state number
  assign start_ok = cmd_i.cfg_we && (cfg_addr_i == REG_START_STATE) &&
                    (cfg_data_i[STATE_W-1:0] < NUM_STATES);

  assign enter  = cmd_i.enter_next || cmd_i.restart || start_ok;
  assign target = cmd_i.enter_next ? cur_e.next :
                  cmd_i.restart    ? COOL_STATE : cfg_data_i[STATE_W-1:0];
  assign tgt_e  = seq_lookup(target);

  always_comb begin
    cur_state_d = cur_state_q;
    elapsed_d   = elapsed_q;
    relay_d     = relay_q;
    batch_d     = batch_q;
    if (enter) begin
      cur_state_d = target;
      elapsed_d   = '0;
      relay_d     = tgt_e.relays;
      if (target == DROP_STATE) begin
        batch_d = batch_q + 1'b1;
      end
    end else if (cmd_i.tick && (elapsed_q != '1)) begin
      elapsed_d = elapsed_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_state_q <= COOL_STATE;
      elapsed_q   <= '0;
      relay_q     <= RLY_COMP_PUMP;
      batch_q     <= '0;
      lim_q[1]    <= MAKE_ICE_RST;
      lim_q[2]    <= DROP_REFILL_RST;
      lim_q[3]    <= DROP_RST;
      lim_q[4]    <= CLEANUP_RST;
    end else begin
      cur_state_q <= cur_state_d;
      elapsed_q   <= elapsed_d;
      relay_q     <= relay_d;
      batch_q     <= batch_d;
      if (cmd_i.cfg_we) begin
        case (cfg_addr_i)
          REG_MAKE_ICE:    lim_q[1] <= cfg_data_i;
          REG_DROP_REFILL: lim_q[2] <= cfg_data_i;
          REG_DROP:        lim_q[3] <= cfg_data_i;
          REG_CLEANUP:     lim_q[4] <= cfg_data_i;
          default:         ;
        endcase
      end
    end
  end

  assign batch_ext = {{BATCH_W{1'b0}}, batch_q};

  // thermostat levels of the beat and the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick || cmd_i.restart) begin
      bin_q  <= in_data_i[0];
      evap_q <= in_data_i[1];
    end
    if (cmd_i.load_out) begin
      out_q <= {4'b0, batch_ext[BATCH_W-1:0], time_left, cur_state_q, relay_q};
    end
  end

  assign out_data_o = out_q;

`ifndef NO_ASSERTIONS
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_state_q < NUM_STATES)
    else $error("state index out of table range");

  a_enter_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.enter_next || cmd_i.restart) |=> (elapsed_q == '0))
    else $error("timer not cleared on state entry");

  a_batch_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (batch_q != $past(batch_q)) |-> (cur_state_q == DROP_STATE))
    else $error("batch count moved outside drop entry");
`endif

endmodule
`default_nettype wire

FILE: src/ice_maker_cycle_sequencer.sv
// flow: a tick beat goes through the test state, one chained entry per pass, then the final state that loads its result
// a restart beat goes straight to the final state; a stalled output holds the final state until it is free
// the input is not ready again until the result is loaded, so a new beat waits until the last one is through
// reset: asynchronous active low; state 0 with relays 10, timer and batch count zero
// dwell limits return to their default values; no clearing pass
`default_nettype none
module ice_maker_cycle_sequencer
  import ims_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int MAX_CHAIN  = MAX_CHAIN_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // bin_thermo, evap_thermo
  input  wire logic                  s_axis_tuser,   // req_type
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // relay_on, state_index, time_left, batches
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [LIMIT_W-1:0]    cfg_data_i
);

  ims_cmd_t cmd;
  ims_sts_t sts;

  ims_ctrl #(
    .MAX_CHAIN(MAX_CHAIN)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .cfg_valid_i,
    .cfg_ready_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  ims_dp #(
    .TIMER_BITS(TIMER_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_addr_i,
    .cfg_data_i,
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata)
  );

endmodule
`default_nettype wire

FILE: test/ims_result_checker.sv
// checker for the ice maker sequencer: follows the cycle table and compares status beats
`timescale 1ns / 100ps
module ims_result_checker
  import ims_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,   // bin_thermo, evap_thermo
  input  wire logic                  in_user_i,   // req_type
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire logic [OUT_DATA_W-1:0] out_data_i,  // relay_on, state_index, time_left, batches
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [LIMIT_W-1:0]    cfg_data_i,
  output int                         pending_o,
  output int                         errors_o
);

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] lim;
    watch_e                bin_w;
    watch_e                evap_w;
    logic [RELAY_W-1:0]    relays;
    logic [STATE_W-1:0]    nxt;
  } row_t;

  // same layout as m_axis_tdata, lowest field last
  typedef struct packed {
    logic [3:0]           pad;
    logic [BATCH_W-1:0]   batches;
    logic [LIMIT_W-1:0]   left;
    logic [STATE_W-1:0]   state;
    logic [RELAY_W-1:0]   relay;
  } status_t;

  status_t                   expected_status[$];
  logic [LIMIT_W-1:0]        dwell_ms[0:4];
  logic [STATE_W-1:0]        cur_state;
  logic [TIMER_BITS_DEF-1:0] elapsed;
  logic [RELAY_W-1:0]        relays;
  logic [BATCH_W-1:0]        batches;
  int                        errors = 0;

  function automatic row_t cycle_row(input logic [STATE_W-1:0] s);
    row_t r;
    case (s)
      4'd0:    r = '{REG_START_STATE, W_NONE, W_HIGH, RLY_COMP_PUMP,     4'd1};
      4'd1:    r = '{REG_MAKE_ICE,    W_NONE, W_NONE, RLY_COMP_PUMP,     4'd2};
      4'd2:    r = '{REG_START_STATE, W_NONE, W_LOW,  RLY_COMP_GAS,      4'd3};
      4'd3:    r = '{REG_START_STATE, W_LOW,  W_NONE, RLY_OFF,           4'd4};
      4'd4:    r = '{REG_DROP_REFILL, W_NONE, W_NONE, RLY_COMP_WTR_GAS,  4'd5};
      4'd5:    r = '{REG_DROP,        W_NONE, W_NONE, RLY_COMP_PUMP_GAS, 4'd0};
      4'd6:    r = '{REG_START_STATE, W_NONE, W_LOW,  RLY_COMP_GAS,      4'd7};
      4'd7:    r = '{REG_CLEANUP,     W_NONE, W_NONE, RLY_PUMP,          4'd8};
      default: r = '{REG_START_STATE, W_NONE, W_NONE, RLY_PUMP_WTR,      4'd7};
    endcase
    return r;
  endfunction

  function automatic logic level_hit(input watch_e w, input logic level);
    return (w == W_LOW && !level) || (w == W_HIGH && level);
  endfunction

  function automatic logic state_done(input logic bin, input logic evap);
    row_t r;
    r = cycle_row(cur_state);
    if (r.lim != REG_START_STATE && elapsed >= dwell_ms[r.lim]) return 1'b1;
    return level_hit(r.evap_w, evap) || level_hit(r.bin_w, bin);
  endfunction

  task automatic enter_state(input logic [STATE_W-1:0] s);
    cur_state = s;
    elapsed   = '0;
    if (s == DROP_STATE) batches = batches + 1'b1;
  endtask

  task automatic advance_cycle(input logic restart, input logic bin, input logic evap);
    row_t    r;
    status_t st;
    int      n;
    if (restart) begin
      enter_state(COOL_STATE);
      relays = RLY_COMP_PUMP;
    end else begin
      if (elapsed != '1) elapsed = elapsed + 1'b1;
      if (state_done(bin, evap)) begin
        n = 0;
        // chained entries within one tick, bounded
        do begin
          r = cycle_row(cur_state);
          enter_state(r.nxt);
          n++;
        end while (n < MAX_CHAIN_DEF && state_done(bin, evap));
        r = cycle_row(cur_state);
        relays = r.relays;
      end
    end
    r = cycle_row(cur_state);
    st.pad     = '0;
    st.relay   = relays;
    st.state   = cur_state;
    st.batches = batches;
    if (r.lim == REG_START_STATE) st.left = NO_LIMIT_LEFT;
    else if (elapsed >= dwell_ms[r.lim]) st.left = '0;
    else st.left = dwell_ms[r.lim] - elapsed;
    expected_status.push_back(st);
  endtask

  task automatic apply_write(input logic [CFG_ADDR_W-1:0] addr, input logic [LIMIT_W-1:0] data);
    row_t r;
    case (addr)
      REG_START_STATE: begin
        // values whose low state bits lie past the last state are dropped
        if (data[STATE_W-1:0] < NUM_STATES) begin
          enter_state(data[STATE_W-1:0]);
          r = cycle_row(cur_state);
          relays = r.relays;
        end
      end
      REG_MAKE_ICE, REG_DROP_REFILL, REG_DROP, REG_CLEANUP: dwell_ms[addr] = data;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    if (errors <= 100) $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
  endtask

  task automatic check_status(input logic [OUT_DATA_W-1:0] data);
    status_t got;
    status_t want;
    got = data;
    if (expected_status.size() == 0) begin
      report_mismatch("status beats waiting", 32'd1, 32'd0);
    end else begin
      want = expected_status.pop_front();
      if (got.relay != want.relay) report_mismatch("relay_on", 32'(want.relay), 32'(got.relay));
      if (got.state != want.state) begin
        report_mismatch("state_index", 32'(want.state), 32'(got.state));
      end
      if (got.left != want.left) report_mismatch("time_left", 32'(want.left), 32'(got.left));
      if (got.batches != want.batches) begin
        report_mismatch("batches", 32'(want.batches), 32'(got.batches));
      end
      if (got.pad != want.pad) report_mismatch("tdata padding", 32'(want.pad), 32'(got.pad));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ms[0]               = '0;
      dwell_ms[REG_MAKE_ICE]    = MAKE_ICE_RST;
      dwell_ms[REG_DROP_REFILL] = DROP_REFILL_RST;
      dwell_ms[REG_DROP]        = DROP_RST;
      dwell_ms[REG_CLEANUP]     = CLEANUP_RST;
      cur_state = COOL_STATE;
      elapsed   = '0;
      relays    = RLY_COMP_PUMP;
      batches   = '0;
      expected_status.delete();
      pending_o <= 0;
    end else begin
      // older beat leaves before a new one is queued
      if (out_valid_i && out_ready_i) check_status(out_data_i);
      if (cfg_valid_i && cfg_ready_i) apply_write(cfg_addr_i, cfg_data_i);
      if (in_valid_i && in_ready_i) advance_cycle(in_user_i, in_data_i[0], in_data_i[1]);
      pending_o <= expected_status.size();
    end
    errors_o <= errors;
  end

endmodule

FILE: test/tb_ice_maker_cycle_sequencer.sv
// testbench top for the ice maker sequencer: stimulus, flow control and verdict
`timescale 1ns / 100ps
module tb_ice_maker_cycle_sequencer
  import ims_pkg::*;
();

  localparam logic        REQ_TICK     = 1'b0;
  localparam logic        REQ_RESTART  = 1'b1;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          PHASES       = 8;
  localparam int          PHASE_BEATS  = 95;
  localparam logic [LIMIT_W-1:0] DWELL_MAX = '1;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [LIMIT_W-1:0]    cfg_data_i    = '0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_ready_o;

  int          pending;
  int          errors;
  int unsigned cycles     = 0;
  int unsigned send_idle  = 0;
  int unsigned recv_stall = 0;
  logic        bin_lvl    = 1'b0;
  logic        evap_lvl   = 1'b0;

  always #1 clk_i = ~clk_i;

  ice_maker_cycle_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  ims_result_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic req, input logic bin, input logic evap);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, evap, bin};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [LIMIT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain every status beat, then give the block time to settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dwell(input logic [LIMIT_W-1:0] make_ice, input logic [LIMIT_W-1:0] refill,
                           input logic [LIMIT_W-1:0] drop, input logic [LIMIT_W-1:0] cleanup);
    cfg_write(REG_MAKE_ICE, make_ice);
    cfg_write(REG_DROP_REFILL, refill);
    cfg_write(REG_DROP, drop);
    cfg_write(REG_CLEANUP, cleanup);
  endtask

  function automatic logic [LIMIT_W-1:0] rand_dwell();
    if ($urandom_range(7) == 0) return '0;
    return LIMIT_W'($urandom_range(1, 40));
  endfunction

  initial begin
    logic [LIMIT_W-1:0] start_val;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: cool down waits on evap, make ice has its full dwell
    send_beat(REQ_TICK, 1'b0, 1'b0);
    send_beat(REQ_TICK, 1'b1, 1'b1);
    send_beat(REQ_TICK, 1'b1, 1'b0);
    send_beat(REQ_RESTART, 1'b1, 1'b1);
    send_beat(REQ_TICK, 1'b0, 1'b1);

    // zero dwell everywhere: long chains through drop
    wait_idle();
    set_dwell('0, '0, '0, '0);
    cfg_write(REG_START_STATE, LIMIT_W'(3));
    send_beat(REQ_TICK, 1'b0, 1'b1);
    send_beat(REQ_TICK, 1'b0, 1'b0);
    send_beat(REQ_TICK, 1'b1, 1'b1);
    send_beat(REQ_TICK, 1'b1, 1'b0);

    // cleanup loop, left only by restart or a start state write
    wait_idle();
    cfg_write(REG_START_STATE, LIMIT_W'(7));
    send_beat(REQ_TICK, 1'b1, 1'b1);
    send_beat(REQ_TICK, 1'b0, 1'b0);
    send_beat(REQ_RESTART, 1'b0, 1'b0);
    wait_idle();
    cfg_write(REG_START_STATE, LIMIT_W'(6));
    send_beat(REQ_TICK, 1'b0, 1'b1);
    send_beat(REQ_TICK, 1'b1, 1'b0);

    // unknown indexes, out-of-range start states, start value with high bits set
    wait_idle();
    cfg_write(3'd5, DWELL_MAX);
    cfg_write(3'd6, LIMIT_W'(1));
    cfg_write(3'd7, LIMIT_W'(5));
    cfg_write(REG_START_STATE, LIMIT_W'(9));
    cfg_write(REG_START_STATE, LIMIT_W'(15));
    cfg_write(REG_START_STATE, LIMIT_W'(21));
    send_beat(REQ_TICK, 1'b1, 1'b0);

    // largest dwell limits
    wait_idle();
    set_dwell(DWELL_MAX, DWELL_MAX, DWELL_MAX, DWELL_MAX);
    cfg_write(REG_START_STATE, LIMIT_W'(1));
    send_beat(REQ_TICK, 1'b0, 1'b0);
    send_beat(REQ_TICK, 1'b1, 1'b1);
    wait_idle();
    cfg_write(REG_START_STATE, LIMIT_W'(4));
    send_beat(REQ_TICK, 1'b0, 1'b1);
    wait_idle();
    cfg_write(REG_START_STATE, {LIMIT_W{1'b1}});
    cfg_write(REG_START_STATE, LIMIT_W'(5));
    send_beat(REQ_TICK, 1'b1, 1'b0);
    wait_idle();
    cfg_write(REG_START_STATE, LIMIT_W'(7));
    send_beat(REQ_TICK, 1'b0, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 81; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 81; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      if (ph == 0) set_dwell('0, '0, '0, '0);
      else if (ph == 5) set_dwell(DWELL_MAX, DWELL_MAX, DWELL_MAX, DWELL_MAX);
      else set_dwell(rand_dwell(), rand_dwell(), rand_dwell(), rand_dwell());
      cfg_write(REG_START_STATE, LIMIT_W'($urandom_range(0, 8)));

      for (int k = 0; k < PHASE_BEATS; k++) begin
        // sender holds off until all status beats are back, then moves the state
        if (k == 47 || (k % 25 == 24 && $urandom_range(1) == 1)) begin
          wait_idle();
          case ($urandom_range(9))
            0:       start_val = LIMIT_W'($urandom_range(9, 15));
            1:       start_val = LIMIT_W'($urandom);
            default: start_val = LIMIT_W'($urandom_range(0, 8));
          endcase
          cfg_write(REG_START_STATE, start_val);
        end
        if ($urandom_range(24) == 0) begin
          send_beat(REQ_RESTART, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          // thermostats drift slowly so that the watched levels come and go
          if ($urandom_range(9) < 3) bin_lvl = ~bin_lvl;
          if ($urandom_range(9) < 3) evap_lvl = ~evap_lvl;
          send_beat(REQ_TICK, bin_lvl, evap_lvl);
        end
      end
    end

    wait_idle();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
